FILE: rtl/tdm_pkg.sv
// ============================================================================
// tdm_pkg - shared types and constants for the tile dedup mapper
// Field widths, register map and the configuration bundle.
// ============================================================================
`default_nettype none

package tdm_pkg;

    localparam int TILE_W          = 64;   // one half of a 16-byte tile
    localparam int MAP_W           = 8;    // tilemap index width
    localparam int FP_W            = 6;    // position within a frame
    localparam int TPF_W           = 7;    // tiles_per_frame register width
    localparam int MAX_FRAME       = 64;   // largest frame size
    localparam int STORE_DEPTH_DEF = 256;  // default tile store depth

    localparam logic [TPF_W-1:0] TPF_RESET = TPF_W'(49);

    // APB register map
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = APB_AW - 2;

    localparam logic [REG_IDX_W-1:0] REG_TPF = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_DUP = REG_IDX_W'(1);

    typedef struct packed {
        logic [TPF_W-1:0] tiles_per_frame;
        logic             duplicate_mode;
    } t_cfg;

endpackage

`default_nettype wire

FILE: rtl/tdm_ram.sv
// ============================================================================
// tdm_ram - generic single-port-write, single-port-read RAM
// One write and one read per cycle, read data registered.
// ============================================================================
`default_nettype none

module tdm_ram #(
    parameter int WIDTH  = 128,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: rtl/tdm_regs.sv
// ============================================================================
// tdm_regs - APB configuration registers
// tiles_per_frame at byte 0, duplicate_mode at byte 4. No wait states.
// ============================================================================
`default_nettype none

module tdm_regs (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [tdm_pkg::APB_AW-1:0]   paddr,
    input  wire logic [tdm_pkg::APB_DW-1:0]   pwdata,
    output logic      [tdm_pkg::APB_DW-1:0]   prdata,
    output logic                              pready,
    output tdm_pkg::t_cfg                     o_cfg
);
    import tdm_pkg::*;

    t_cfg                 r_cfg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_strobe;

    assign reg_idx   = paddr[APB_AW-1:2];
    assign pready    = 1'b1;
    assign wr_strobe = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tiles_per_frame <= TPF_RESET;
            r_cfg.duplicate_mode  <= 1'b0;
        end else if (wr_strobe) begin
            unique case (reg_idx)
                REG_TPF: r_cfg.tiles_per_frame <= pwdata[TPF_W-1:0];
                REG_DUP: r_cfg.duplicate_mode  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_TPF: prdata = APB_DW'(r_cfg.tiles_per_frame);
            REG_DUP: prdata = APB_DW'(r_cfg.duplicate_mode);
            default: prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: rtl/tile_dedup_mapper_unit.sv
// ============================================================================
// tile_dedup_mapper_unit - deduplicating tilemap builder for 2bpp 8x8 tiles
// Stores unique tiles in an on-chip store and maps each incoming tile to a
// tilemap index, emitting tile data for every newly stored tile.
// ============================================================================
// One tile is processed at a time: a transaction is taken when start is high
// and busy is low, and busy stays high until its last result has been put on
// the result ports. Each result is shown for exactly one cycle with o_valid
// high and cannot be stalled; o_final_result marks the last result of a
// tile. A first-frame tile goes through accept, check and result. A later
// tile that hits the store entry at its frame position goes through accept,
// check, compare and result; a miss there scans the store one entry per
// cycle through the single read port of the tile RAM. In duplicate mode the
// last tile adds a read of entry 0 and a second result, its trailing copy.
// The store needs no clearing pass: only entries below the running count
// are ever read. Configuration must be written through APB only while busy
// is low; the block itself has no check that enforces this.
// ============================================================================
`default_nettype none

module tile_dedup_mapper_unit #(
    parameter int STORE_DEPTH = tdm_pkg::STORE_DEPTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // command channel
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [tdm_pkg::TILE_W-1:0]  i_tile_low,
    input  wire logic [tdm_pkg::TILE_W-1:0]  i_tile_high,
    input  wire logic                        i_first_tile,
    input  wire logic                        i_last_tile,
    // result channel
    output logic                             o_valid,
    output logic      [tdm_pkg::MAP_W-1:0]   o_map_index,
    output logic                             o_appended,
    output logic      [tdm_pkg::TILE_W-1:0]  o_out_low,
    output logic      [tdm_pkg::TILE_W-1:0]  o_out_high,
    output logic                             o_tail_copy,
    output logic                             o_final_result,
    output logic                             o_overflow,
    // APB configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [tdm_pkg::APB_AW-1:0]  paddr,
    input  wire logic [tdm_pkg::APB_DW-1:0]  pwdata,
    output logic      [tdm_pkg::APB_DW-1:0]  prdata,
    output logic                             pready
);
    import tdm_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);      // store address
    localparam int CW = $clog2(STORE_DEPTH + 1);  // count, can hold the depth
    localparam int DW = 2 * TILE_W;               // whole tile

    // Sequencer states
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,  // wait for start
        S_CHK  = 7'b0000010,  // pick path, read preferred entry
        S_PCMP = 7'b0000100,  // compare preferred entry
        S_SCAN = 7'b0001000,  // linear scan, one entry per cycle
        S_RES  = 7'b0010000,  // decide, append, emit main result
        S_TRD  = 7'b0100000,  // read entry 0 for the tail copy
        S_TAIL = 7'b1000000   // append and emit tail copy
    } t_state;

    t_cfg cfg;

    // control state
    t_state           r_state,   n_state;
    logic [CW-1:0]    r_count,   n_count;    // unique tiles stored
    logic [FP_W-1:0]  r_fp,      n_fp;       // position within frame
    logic             r_iff,     n_iff;      // still in first frame
    logic [CW-1:0]    r_scan,    n_scan;     // next scan address
    logic             r_cmp_vld, n_cmp_vld;  // read data of a scan read pending
    logic             r_out_vld, n_out_vld;

    // payload
    logic [TILE_W-1:0] r_lo,      n_lo;
    logic [TILE_W-1:0] r_hi,      n_hi;
    logic              r_last,    n_last;
    logic [AW-1:0]     r_cmp_idx, n_cmp_idx;
    logic              r_found,   n_found;
    logic [AW-1:0]     r_midx,    n_midx;
    logic [MAP_W-1:0]  r_map,     n_map;
    logic              r_app,     n_app;
    logic [TILE_W-1:0] r_olo,     n_olo;
    logic [TILE_W-1:0] r_ohi,     n_ohi;
    logic              r_tail,    n_tail;
    logic              r_fin,     n_fin;
    logic              r_ovf,     n_ovf;

    // store port signals
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [DW-1:0] rd_data;

    // misc
    logic             tile_hit;
    logic             cnt_full;
    logic             pref_ok;
    logic             scan_issue;
    logic             tail_now;
    logic [TPF_W-1:0] frame_n;
    logic [TPF_W-1:0] fp_inc;

    tdm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Tile store: both halves side by side in one RAM word.
    tdm_ram #(
        .WIDTH (DW),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign tile_hit   = (rd_data == {r_hi, r_lo});
    assign cnt_full   = (r_count == CW'(STORE_DEPTH));
    assign pref_ok    = (CW'(r_fp) < r_count);
    assign scan_issue = (r_scan < r_count);
    assign tail_now   = r_last && cfg.duplicate_mode;
    assign fp_inc     = TPF_W'(r_fp) + TPF_W'(1);

    // Frame size clamped to 1..64
    always_comb begin
        if (cfg.tiles_per_frame == '0) begin
            frame_n = TPF_W'(1);
        end else if (cfg.tiles_per_frame > TPF_W'(MAX_FRAME)) begin
            frame_n = TPF_W'(MAX_FRAME);
        end else begin
            frame_n = cfg.tiles_per_frame;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_fp      = r_fp;
        n_iff     = r_iff;
        n_scan    = r_scan;
        n_cmp_vld = r_cmp_vld;
        n_out_vld = 1'b0;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_last    = r_last;
        n_cmp_idx = r_cmp_idx;
        n_found   = r_found;
        n_midx    = r_midx;
        n_map     = r_map;
        n_app     = r_app;
        n_olo     = r_olo;
        n_ohi     = r_ohi;
        n_tail    = r_tail;
        n_fin     = r_fin;
        n_ovf     = r_ovf;

        wr_en   = 1'b0;
        wr_addr = r_count[AW-1:0];
        wr_data = {r_hi, r_lo};
        rd_en   = 1'b0;
        rd_addr = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_lo   = i_tile_low;
                    n_hi   = i_tile_high;
                    n_last = i_last_tile;
                    // a new image restarts count, position and first frame
                    if (i_first_tile) begin
                        n_count = '0;
                        n_fp    = '0;
                        n_iff   = 1'b1;
                    end
                    n_state = S_CHK;
                end
            end

            S_CHK: begin
                if (r_iff) begin
                    // first frame: stored without a compare, unless the store is full
                    n_found = 1'b0;
                    n_state = S_RES;
                end else if (pref_ok) begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(r_fp);
                    n_state = S_PCMP;
                end else begin
                    n_scan    = '0;
                    n_cmp_vld = 1'b0;
                    n_state   = S_SCAN;
                end
            end

            S_PCMP: begin
                if (tile_hit) begin
                    n_found = 1'b1;
                    n_midx  = AW'(r_fp);
                    n_state = S_RES;
                end else begin
                    n_scan    = '0;
                    n_cmp_vld = 1'b0;
                    n_state   = S_SCAN;
                end
            end

            S_SCAN: begin
                // read issued here, compared the cycle after
                if (r_cmp_vld && tile_hit) begin
                    n_found   = 1'b1;
                    n_midx    = r_cmp_idx;
                    n_cmp_vld = 1'b0;
                    n_state   = S_RES;
                end else if (scan_issue) begin
                    rd_en     = 1'b1;
                    rd_addr   = r_scan[AW-1:0];
                    n_scan    = r_scan + CW'(1);
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_scan[AW-1:0];
                end else begin
                    n_found   = 1'b0;
                    n_cmp_vld = 1'b0;
                    n_state   = S_RES;
                end
            end

            S_RES: begin
                n_out_vld = 1'b1;
                n_tail    = 1'b0;
                n_fin     = !tail_now;
                n_app     = 1'b0;
                n_ovf     = 1'b0;
                n_map     = '0;
                n_olo     = '0;
                n_ohi     = '0;
                if (!r_iff && cfg.duplicate_mode && r_found && (r_midx == '0)) begin
                    // entry-0 match in duplicate mode maps to the count
                    if (cnt_full) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_map = MAP_W'(r_count);
                    end
                end else if (r_iff || !r_found) begin
                    if (cnt_full) begin
                        n_ovf = 1'b1;
                    end else begin
                        wr_en   = 1'b1;
                        n_map   = MAP_W'(r_count);
                        n_count = r_count + CW'(1);
                        n_app   = 1'b1;
                        n_olo   = r_lo;
                        n_ohi   = r_hi;
                    end
                end else begin
                    n_map = MAP_W'(r_midx);
                end
                // advance frame position; wrapping ends the first frame
                if (fp_inc >= frame_n) begin
                    n_fp  = '0;
                    n_iff = 1'b0;
                end else begin
                    n_fp = fp_inc[FP_W-1:0];
                end
                n_state = tail_now ? S_TRD : S_IDLE;
            end

            S_TRD: begin
                // entry 0 is always written by now; an append at 0 in
                // S_RES lands before this read
                rd_en   = 1'b1;
                rd_addr = '0;
                n_state = S_TAIL;
            end

            S_TAIL: begin
                n_out_vld = 1'b1;
                n_tail    = 1'b1;
                n_fin     = 1'b1;
                if (cnt_full) begin
                    n_map = '0;
                    n_app = 1'b0;
                    n_olo = '0;
                    n_ohi = '0;
                    n_ovf = 1'b1;
                end else begin
                    wr_en   = 1'b1;
                    wr_data = rd_data;
                    n_map   = MAP_W'(r_count);
                    n_count = r_count + CW'(1);
                    n_app   = 1'b1;
                    n_olo   = rd_data[TILE_W-1:0];
                    n_ohi   = rd_data[DW-1:TILE_W];
                    n_ovf   = 1'b0;
                end
                n_state = S_IDLE;
            end

            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_fp      <= '0;
            r_iff     <= 1'b1;
            r_scan    <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_fp      <= n_fp;
            r_iff     <= n_iff;
            r_scan    <= n_scan;
            r_cmp_vld <= n_cmp_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_last    <= n_last;
        r_cmp_idx <= n_cmp_idx;
        r_found   <= n_found;
        r_midx    <= n_midx;
        r_map     <= n_map;
        r_app     <= n_app;
        r_olo     <= n_olo;
        r_ohi     <= n_ohi;
        r_tail    <= n_tail;
        r_fin     <= n_fin;
        r_ovf     <= n_ovf;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_out_vld;
    assign o_map_index    = r_map;
    assign o_appended     = r_app;
    assign o_out_low      = r_olo;
    assign o_out_high     = r_ohi;
    assign o_tail_copy    = r_tail;
    assign o_final_result = r_fin;
    assign o_overflow     = r_ovf;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STORE_DEPTH))
        else $error("unique count exceeds store depth");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> $past(r_state == S_RES || r_state == S_TAIL))
        else $error("result strobe without a result state");

    a_busy_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> (o_valid && o_final_result))
        else $error("transaction ended without a final result");

    a_app_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_appended && o_overflow))
        else $error("result both appended and overflowed");

    a_tail_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_tail_copy) |-> o_final_result)
        else $error("tail copy not marked final");

endmodule

`default_nettype wire
